>>> design/pfgb_pkg.sv
// Shared definitions for the page framebuffer glyph blitter.
// Holds request codes, the glyph job record, the font tables and the glyph row lookup.
// Depends on nothing; every other design file imports it.
package pfgb_pkg;

    localparam int DEF_DISPLAY_WIDTH  = 128;
    localparam int DEF_DISPLAY_HEIGHT = 64;

    localparam int GLYPH_COLS = 8;
    localparam int DIGIT_ROWS = 16;
    localparam int SMALL_ROWS = 8;
    localparam int DIGIT_COUNT = 10;
    localparam int MAX_DIGIT = 9;

    // A glyph of up to 16 rows at any vertical offset touches at most three pages.
    localparam int DRAW_PAGES = 3;
    localparam int DRAW_STEPS = GLYPH_COLS * DRAW_PAGES;
    localparam int STEP_W = $clog2(DRAW_STEPS);

    typedef logic [1:0] req_t;
    typedef logic [7:0] byte_t;

    localparam req_t REQ_FILL    = 2'd0;
    localparam req_t REQ_DIGIT   = 2'd1;
    localparam req_t REQ_SMALL_G = 2'd2;
    localparam req_t REQ_READ    = 2'd3;

    typedef struct packed {
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       is_digit;
        logic [3:0] digit;
    } glyph_job_t;

    localparam byte_t DIGIT_ROM [DIGIT_COUNT][DIGIT_ROWS] = '{
        '{8'h00, 8'h00, 8'h3C, 8'h66, 8'hC3, 8'hC3, 8'hC3, 8'hC3,
          8'hC3, 8'hC3, 8'hC3, 8'hC3, 8'h66, 8'h3C, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h18, 8'h38, 8'h78, 8'h18, 8'h18, 8'h18,
          8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h7C, 8'hC6, 8'h06, 8'h0C, 8'h18, 8'h30,
          8'h60, 8'hC0, 8'hC6, 8'hC6, 8'hC6, 8'hFE, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h7C, 8'hC6, 8'h06, 8'h06, 8'h06, 8'h3C,
          8'h06, 8'h06, 8'h06, 8'h06, 8'hC6, 8'h7C, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h0C, 8'h1C, 8'h3C, 8'h6C, 8'hCC, 8'hFE,
          8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h0C, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'hFE, 8'hC0, 8'hC0, 8'hC0, 8'hC0, 8'hFC,
          8'h06, 8'h06, 8'h06, 8'h06, 8'hC6, 8'h7C, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h38, 8'h60, 8'hC0, 8'hC0, 8'hC0, 8'hFC,
          8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'h7C, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'hFE, 8'hC6, 8'h06, 8'h06, 8'h0C, 8'h18,
          8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h7C, 8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'h7C,
          8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'h7C, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h7C, 8'hC6, 8'hC6, 8'hC6, 8'hC6, 8'h7E,
          8'h06, 8'h06, 8'h06, 8'h0C, 8'h78, 8'h70, 8'h00, 8'h00}
    };

    localparam byte_t SMALL_G_ROM [SMALL_ROWS] = '{
        8'h00, 8'h00, 8'h3E, 8'h41, 8'h41, 8'h3E, 8'h02, 8'h3C
    };

    function automatic byte_t glyph_row(input logic is_digit, input logic [3:0] digit,
                                        input logic [3:0] row);
        byte_t bits;
        bits = 8'h00;
        if (is_digit)
        begin
            if (digit <= 4'(MAX_DIGIT))
            begin
                bits = DIGIT_ROM[digit][row];
            end
        end
        else
        begin
            bits = SMALL_G_ROM[row[2:0]];
        end
        return bits;
    endfunction

endpackage

>>> design/pfgb_stroke_gen.sv
// Address and pixel mask generator for one glyph step: one column of one page.
// The mask holds the glyph pixels in that framebuffer byte, clipped to the display height.
// Depends on pfgb_pkg for the job record, the step width and the font lookup.
module pfgb_stroke_gen #(
    parameter int DISPLAY_WIDTH  = pfgb_pkg::DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = pfgb_pkg::DEF_DISPLAY_HEIGHT,
    localparam int PAGE_COUNT    = (DISPLAY_HEIGHT + 7) / 8,
    localparam int STORE_BYTES   = DISPLAY_WIDTH * PAGE_COUNT,
    localparam int ADDR_W        = $clog2(STORE_BYTES)
) (
    input  pfgb_pkg::glyph_job_t          job,
    input  logic [pfgb_pkg::STEP_W-1:0]   step,
    output logic [ADDR_W-1:0]             addr,
    output pfgb_pkg::byte_t               mask,
    output logic                          hit
);
    import pfgb_pkg::*;

    logic [2:0]  col_off;
    logic [1:0]  page_off;
    logic [5:0]  page;
    logic [8:0]  col;
    logic [8:0]  row_base;
    logic [4:0]  row_count;
    logic [31:0] addr_full;

    always_comb
    begin
        col_off   = step[2:0];
        page_off  = step[4:3];
        page      = 6'(job.pos_y[7:3]) + 6'(page_off);
        col       = 9'(job.pos_x) + 9'(col_off);
        row_base  = {page, 3'b000};
        row_count = job.is_digit ? 5'(DIGIT_ROWS) : 5'(SMALL_ROWS);
        hit       = (32'(page) < 32'(PAGE_COUNT)) && (32'(col) < 32'(DISPLAY_WIDTH));
        addr_full = 32'(col) + 32'(page) * 32'(DISPLAY_WIDTH);
        addr      = addr_full[ADDR_W-1:0];
    end

    for (genvar b = 0; b < 8; b++)
    begin : g_bit
        logic [8:0] row;
        logic [8:0] rel;
        logic       covered;
        byte_t      bits;

        assign row     = row_base + 9'(b);
        assign rel     = row - 9'(job.pos_y);
        assign covered = (row >= 9'(job.pos_y)) && (rel < 9'(row_count))
                         && (32'(row) < 32'(DISPLAY_HEIGHT));
        assign bits    = glyph_row(job.is_digit, job.digit, rel[3:0]);
        assign mask[b] = covered & bits[col_off];
    end

endmodule

>>> design/page_framebuffer_glyph_blitter_core.sv
// Top level of the page framebuffer glyph blitter: sequencer and framebuffer memory.
// Depends on pfgb_pkg and instantiates pfgb_stroke_gen.
//
// Usage: a request is transferred at a rising edge where start is high and busy is low.
// Every request produces exactly one result: done pulses for one cycle with read_data
// and rejected. The receiver cannot stall, so results are never held back.
// The framebuffer is one single-port-write, registered-read memory of
// DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8) bytes, one byte per access.
// Work done for each request before done goes high:
//   read: one memory read; rejected digit or read beyond the store: none, done in the next cycle;
//   glyph draw: 24 column/page read-modify-writes, one per cycle, pipelined with each write
//   registered behind its read, plus the final write;
//   fill: all STORE_BYTES bytes, one byte written per cycle.
// Requests are taken one at a time; busy is high while one is in progress.
// After reset the block sweeps all STORE_BYTES bytes of the memory to zero, one byte per cycle,
// with busy high; no request is taken until it ends.
module page_framebuffer_glyph_blitter_core #(
    parameter int DISPLAY_WIDTH  = pfgb_pkg::DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = pfgb_pkg::DEF_DISPLAY_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pfgb_pkg::req_t        req_type,
    input  logic [7:0]            pos_x,
    input  logic [7:0]            pos_y,
    input  logic [7:0]            digit_value,
    input  logic                  fill_on,
    input  logic [9:0]            read_index,
    output logic                  done,
    output logic [7:0]            read_data,
    output logic                  rejected
);
    import pfgb_pkg::*;

    localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_DRAW  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    byte_t mem [STORE_BYTES];
    byte_t mem_q_reg;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [STEP_W-1:0] step_reg, step_next;
    glyph_job_t        job_reg, job_next;
    logic              fill_reg, fill_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    byte_t             pend_mask_reg, pend_mask_next;
    logic              done_reg, done_next;
    byte_t             data_reg, data_next;
    logic              rej_reg, rej_next;

    logic [ADDR_W-1:0] gen_addr;
    byte_t             gen_mask;
    logic              gen_hit;
    logic [31:0]       rd_idx_ext;
    logic              rd_in_range;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] wa;
    byte_t             wd;

    pfgb_stroke_gen #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_stroke_gen (
        .job  (job_reg),
        .step (step_reg),
        .addr (gen_addr),
        .mask (gen_mask),
        .hit  (gen_hit)
    );

    assign rd_idx_ext  = 32'(read_index);
    assign rd_in_range = rd_idx_ext < 32'(STORE_BYTES);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        job_next       = job_reg;
        fill_next      = fill_reg;
        pend_next      = 1'b0;
        pend_addr_next = gen_addr;
        pend_mask_next = gen_mask;
        done_next      = 1'b0;
        data_next      = 8'h00;
        rej_next       = 1'b0;
        rd_addr        = gen_addr;
        we             = 1'b0;
        wa             = pend_addr_reg;
        wd             = mem_q_reg | pend_mask_reg;

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                wa = cnt_reg;
                wd = 8'h00;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                rd_addr = rd_idx_ext[ADDR_W-1:0];
                if (start)
                begin
                    job_next.pos_x    = pos_x;
                    job_next.pos_y    = pos_y;
                    job_next.is_digit = (req_type == REQ_DIGIT);
                    job_next.digit    = digit_value[3:0];
                    fill_next         = fill_on;
                    step_next         = '0;
                    cnt_next          = '0;
                    case (req_type)
                        REQ_FILL:
                        begin
                            state_next = S_FILL;
                        end
                        REQ_DIGIT:
                        begin
                            if (digit_value > 8'(MAX_DIGIT))
                            begin
                                done_next = 1'b1;
                                rej_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DRAW;
                            end
                        end
                        REQ_SMALL_G:
                        begin
                            state_next = S_DRAW;
                        end
                        default:
                        begin
                            if (rd_in_range)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                we = 1'b1;
                wa = cnt_reg;
                wd = fill_reg ? 8'hFF : 8'h00;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAW:
            begin
                we        = pend_reg;
                pend_next = gen_hit;
                if (step_reg == STEP_W'(DRAW_STEPS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                we         = pend_reg;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                done_next  = 1'b1;
                data_next  = mem_q_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            step_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            data_reg  <= 8'h00;
            rej_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            data_reg  <= data_next;
            rej_reg   <= rej_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        fill_reg      <= fill_next;
        pend_addr_reg <= pend_addr_next;
        pend_mask_reg <= pend_mask_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign read_data = data_reg;
    assign rejected  = rej_reg;

    // A pending write exists only while a glyph is being drawn.
    a_pend_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_DRAW || state_reg == S_DRAIN))
        else $error("pending glyph write outside a draw");

    // A result is only ever shown once the block has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result shown while busy");

    // A transferred request either starts work or finishes at once.
    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("transferred request was dropped");

    // Result fields are zero except in the cycle of a result.
    a_fields_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        ((data_reg != 8'h00) || rej_reg) |-> done_reg)
        else $error("result fields set without a result");

endmodule
